// ===== src/wsts_pkg.sv =====
// Shared types and constants for the weighted sum tree sampler.
package wsts_pkg;

   localparam int IDX_BITS      = 10;
   localparam int WEIGHT_BITS   = 32;
   localparam int SUM_BITS      = 42;
   localparam int FRAC_IN_BITS  = 16;
   localparam int HALF_BITS     = SUM_BITS / 2;
   localparam int PROD_HALF_W   = FRAC_IN_BITS + HALF_BITS;
   localparam int PROD_W        = FRAC_IN_BITS + SUM_BITS;
   localparam int WORD_W        = WEIGHT_BITS + SUM_BITS;

   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]              operation;
      logic                    weight_set;
      logic [IDX_BITS-1:0]     node_index;
      logic [WEIGHT_BITS-1:0]  new_weight;
      logic [FRAC_IN_BITS-1:0] cutoff_fraction;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]    chosen_node;
      logic [WEIGHT_BITS-1:0] node_weight;
      logic [SUM_BITS-1:0]    total_weight;
      logic [1:0]             error;
   } rsp_type;

   typedef enum logic [3:0] {
      STEP_NONE    = 4'd0,
      STEP_FETCH   = 4'd1,
      STEP_READ    = 4'd2,
      STEP_SMP_CHK = 4'd3,
      STEP_MUL_LO  = 4'd4,
      STEP_MUL_HI  = 4'd5,
      STEP_MUL_SUM = 4'd6,
      STEP_CUT     = 4'd7,
      STEP_UPD_B   = 4'd8,
      STEP_UPD_C   = 4'd9,
      STEP_DSC_RD  = 4'd10,
      STEP_DSC_B   = 4'd11,
      STEP_DSC_C   = 4'd12
   } step_type;

   typedef struct packed {
      logic     load;
      logic     clear;
      logic     rsp_load;
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic sample;
      logic set_ok;
      logic root_zero;
      logic at_root;
      logic dsc_stop;
      logic clr_last;
   } status_type;

endpackage

// ===== src/weighted_sum_tree_sampler_core.sv =====
// Top level of the weighted sum tree sampler.
//
//   port group  dir  handshake              word
//   req_        in   req_valid/req_ready    wsts_pkg::req_type
//   rsp_        out  rsp_valid/rsp_ready    wsts_pkg::rsp_type
//
// One word at a time. Read: fetch and read. Set: update states for each tree level
// on the path to the root. Sample: root check, multiply, cutoff, then read,
// compare and step per level descended, or stop at an empty root. Both walks are
// bound by the two-port tree memory. After reset a clearing pass writes
// 2 * 2^ceil(log2 NODES) entries, one per cycle, before req_ready rises. A stalled
// result waits in its output register while the next word is taken and worked on.
module weighted_sum_tree_sampler_core #(
   parameter int NODES         = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wsts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wsts_pkg::rsp_type rsp_data
);

   wsts_pkg::cmd_type    cmd;
   wsts_pkg::status_type status;

   wsts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wsts_dpath #(
      .NODES         (NODES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== src/wsts_dpath.sv =====
// Datapath: tree memory, update and descent arithmetic, cutoff multiply, result register.
module wsts_dpath #(
   parameter int NODES         = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wsts_pkg::req_type      req_data,
   input  wsts_pkg::cmd_type      cmd,
   output wsts_pkg::status_type   status,
   output wsts_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(NODES);
   localparam int XW    = ((IDX_W > wsts_pkg::IDX_BITS) ? IDX_W : wsts_pkg::IDX_BITS) + 2;
   localparam int AW    = IDX_W + 1;
   localparam int DEPTH = 2 ** AW;
   localparam int SW    = wsts_pkg::SUM_BITS;
   localparam int WW    = wsts_pkg::WEIGHT_BITS;
   localparam int PW    = wsts_pkg::PROD_W;
   localparam logic [XW-1:0] NODES_X = XW'(NODES);

   logic [wsts_pkg::WORD_W-1:0] mem [DEPTH];

   wsts_pkg::req_type req_ff;
   wsts_pkg::rsp_type rsp_ff;
   wsts_pkg::rsp_type rsp_in;

   logic [AW-1:0]    clr_ff, clr_in;
   logic [IDX_W-1:0] node_ff;
   logic             leaf_ff;
   logic             empty_ff;
   logic             hit_ff;
   logic [WW-1:0]    w_ff;
   logic [SW-1:0]    sum_ff, total_ff, c_ff, c2_ff, ls_ff;
   logic [SW:0]      part_ff;
   logic [wsts_pkg::PROD_HALF_W-1:0] prod_lo_ff, prod_hi_ff;
   logic [PW-1:0]    prod_ff;
   logic [wsts_pkg::WORD_W-1:0] rd0_ff, rd1_ff;
   logic             valid0_ff, valid1_ff;

   logic [XW-1:0] idx_x, idx_left_x, idx_right_x;
   logic [XW-1:0] node_x, left_x, right_x, parent_x, sib_x;
   logic [XW-1:0] ra0, ra1;
   logic          rd_en;
   logic          is_sample, is_set, in_range, set_ok, range_err;
   logic [WW-1:0] rd0_w;
   logic [SW-1:0] rd0_s, rd1_s;
   logic          we;
   logic [AW-1:0] wa;
   logic [wsts_pkg::WORD_W-1:0] wd;
   logic [SW+1:0] full_sum;
   logic [SW-1:0] sat_sum;
   logic [PW:0]   cut_q, cut_tot;
   logic [SW-1:0] cut_c;
   logic [SW-1:0] c1;
   logic          go_right, stop;

   assign idx_x       = XW'(req_ff.node_index);
   assign idx_left_x  = {idx_x[XW-2:0], 1'b1};
   assign idx_right_x = idx_left_x + XW'(1);
   assign node_x      = XW'(node_ff);
   assign left_x      = {node_x[XW-2:0], 1'b1};
   assign right_x     = left_x + XW'(1);
   assign parent_x    = (node_x - XW'(1)) >> 1;
   assign sib_x       = node_ff[0] ? (node_x + XW'(1)) : (node_x - XW'(1));

   assign is_sample = (req_ff.operation == wsts_pkg::OP_SAMPLE);
   assign is_set    = (req_ff.operation == wsts_pkg::OP_SET);
   assign in_range  = (idx_x < NODES_X);
   assign set_ok    = is_set && in_range;
   assign range_err = !is_sample && !in_range;

   // Entries past the last node read as zero.
   assign rd0_w = valid0_ff ? rd0_ff[wsts_pkg::WORD_W-1:SW] : '0;
   assign rd0_s = valid0_ff ? rd0_ff[SW-1:0] : '0;
   assign rd1_s = valid1_ff ? rd1_ff[SW-1:0] : '0;

   always_comb begin
      ra0   = idx_x;
      ra1   = '0;
      rd_en = 1'b0;
      case (cmd.step)
         wsts_pkg::STEP_FETCH: begin
            rd_en = 1'b1;
            if (is_sample) begin
               ra0 = '0;
               ra1 = XW'(1);
            end else if (set_ok) begin
               ra0 = idx_left_x;
               ra1 = idx_right_x;
            end
         end
         wsts_pkg::STEP_UPD_C: begin
            rd_en = 1'b1;
            ra0   = parent_x;
            ra1   = sib_x;
         end
         wsts_pkg::STEP_DSC_RD: begin
            rd_en = 1'b1;
            ra0   = node_x;
            ra1   = left_x;
         end
         default: begin
         end
      endcase
   end

   // Update arithmetic: node sum = weight + both child sums, saturated.
   assign full_sum = {1'b0, part_ff} + (SW+2)'(w_ff);
   assign sat_sum  = (full_sum > (SW+2)'(wsts_pkg::SUM_MAX)) ? wsts_pkg::SUM_MAX
                                                            : full_sum[SW-1:0];

   // Cutoff = floor(frac * total / 2^FRACTION_BITS) + 1, clamped to total.
   assign cut_q   = (PW+1)'(prod_ff >> FRACTION_BITS) + (PW+1)'(1);
   assign cut_tot = (PW+1)'(total_ff);
   assign cut_c   = (cut_q > cut_tot) ? total_ff : cut_q[SW-1:0];

   assign c1 = (c_ff > rd0_s) ? rd0_s : c_ff;

   assign go_right = (c2_ff > ls_ff);
   assign stop     = hit_ff || (go_right ? (right_x >= NODES_X) : (left_x >= NODES_X));

   assign we = cmd.clear || (cmd.step == wsts_pkg::STEP_UPD_C);
   assign wa = cmd.clear ? clr_ff : {req_ff.weight_set, node_ff};
   assign wd = cmd.clear ? '0 : {w_ff, sat_sum};

   assign clr_in = cmd.clear ? (clr_ff + AW'(1)) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd0_ff    <= mem[{req_ff.weight_set, ra0[IDX_W-1:0]}];
         rd1_ff    <= mem[{req_ff.weight_set, ra1[IDX_W-1:0]}];
         valid0_ff <= (ra0 < NODES_X);
         valid1_ff <= (ra1 < NODES_X);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_data;
         leaf_ff <= 1'b1;
      end
      case (cmd.step)
         wsts_pkg::STEP_FETCH: begin
            node_ff <= set_ok ? idx_x[IDX_W-1:0] : '0;
         end
         wsts_pkg::STEP_READ: begin
            w_ff     <= rd0_w;
            total_ff <= rd1_s;
         end
         wsts_pkg::STEP_SMP_CHK: begin
            total_ff <= rd0_s;
            empty_ff <= (rd0_s == '0);
         end
         wsts_pkg::STEP_MUL_LO: begin
            prod_lo_ff <= wsts_pkg::PROD_HALF_W'(req_ff.cutoff_fraction)
                        * wsts_pkg::PROD_HALF_W'(total_ff[wsts_pkg::HALF_BITS-1:0]);
         end
         wsts_pkg::STEP_MUL_HI: begin
            prod_hi_ff <= wsts_pkg::PROD_HALF_W'(req_ff.cutoff_fraction)
                        * wsts_pkg::PROD_HALF_W'(total_ff[SW-1:wsts_pkg::HALF_BITS]);
         end
         wsts_pkg::STEP_MUL_SUM: begin
            prod_ff <= {prod_hi_ff, {wsts_pkg::HALF_BITS{1'b0}}} + PW'(prod_lo_ff);
         end
         wsts_pkg::STEP_CUT: begin
            c_ff <= cut_c;
         end
         wsts_pkg::STEP_UPD_B: begin
            w_ff    <= leaf_ff ? req_ff.new_weight : rd0_w;
            part_ff <= {1'b0, (leaf_ff ? rd0_s : sum_ff)} + {1'b0, rd1_s};
         end
         wsts_pkg::STEP_UPD_C: begin
            sum_ff   <= sat_sum;
            total_ff <= sat_sum;
            leaf_ff  <= 1'b0;
            if (node_ff != '0) begin
               node_ff <= parent_x[IDX_W-1:0];
            end
         end
         wsts_pkg::STEP_DSC_B: begin
            hit_ff <= (c1 <= SW'(rd0_w));
            c2_ff  <= c1 - SW'(rd0_w);
            ls_ff  <= rd1_s;
            w_ff   <= rd0_w;
         end
         wsts_pkg::STEP_DSC_C: begin
            if (!stop) begin
               node_ff <= go_right ? right_x[IDX_W-1:0] : left_x[IDX_W-1:0];
               c_ff    <= go_right ? (c2_ff - ls_ff) : c2_ff;
            end
         end
         default: begin
         end
      endcase
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in.total_weight = total_ff;
      if (is_sample) begin
         rsp_in.chosen_node = empty_ff ? '0 : wsts_pkg::IDX_BITS'(node_ff);
         rsp_in.node_weight = empty_ff ? '0 : w_ff;
         rsp_in.error       = empty_ff ? wsts_pkg::ERR_EMPTY : wsts_pkg::ERR_NONE;
      end else begin
         rsp_in.chosen_node = req_ff.node_index;
         rsp_in.node_weight = range_err ? '0 : (is_set ? req_ff.new_weight : w_ff);
         rsp_in.error       = range_err ? wsts_pkg::ERR_RANGE : wsts_pkg::ERR_NONE;
      end
   end

   assign status.sample    = is_sample;
   assign status.set_ok    = set_ok;
   assign status.root_zero = (rd0_s == '0);
   assign status.at_root   = (node_ff == '0);
   assign status.dsc_stop  = stop;
   assign status.clr_last  = &clr_ff;

   assign rsp_data = rsp_ff;

endmodule

// ===== src/wsts_ctrl.sv =====
// Controller: sequences clearing, update walk, cutoff multiply and descent.
module wsts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  wsts_pkg::status_type status,
   output wsts_pkg::cmd_type    cmd
);

   typedef enum logic [14:0] {
      ST_CLEAR   = 15'b000000000000001,
      ST_IDLE    = 15'b000000000000010,
      ST_FETCH   = 15'b000000000000100,
      ST_READ    = 15'b000000000001000,
      ST_SMP_CHK = 15'b000000000010000,
      ST_MUL_LO  = 15'b000000000100000,
      ST_MUL_HI  = 15'b000000001000000,
      ST_MUL_SUM = 15'b000000010000000,
      ST_CUT     = 15'b000000100000000,
      ST_UPD_B   = 15'b000001000000000,
      ST_UPD_C   = 15'b000010000000000,
      ST_DSC_RD  = 15'b000100000000000,
      ST_DSC_B   = 15'b001000000000000,
      ST_DSC_C   = 15'b010000000000000,
      ST_DONE    = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load     = 1'b0;
      cmd.clear    = 1'b0;
      cmd.rsp_load = 1'b0;
      cmd.step     = wsts_pkg::STEP_NONE;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.step = wsts_pkg::STEP_FETCH;
            if (status.sample) begin
               state_in = ST_SMP_CHK;
            end else if (status.set_ok) begin
               state_in = ST_UPD_B;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.step = wsts_pkg::STEP_READ;
            state_in = ST_DONE;
         end
         ST_SMP_CHK: begin
            cmd.step = wsts_pkg::STEP_SMP_CHK;
            state_in = status.root_zero ? ST_DONE : ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.step = wsts_pkg::STEP_MUL_LO;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.step = wsts_pkg::STEP_MUL_HI;
            state_in = ST_MUL_SUM;
         end
         ST_MUL_SUM: begin
            cmd.step = wsts_pkg::STEP_MUL_SUM;
            state_in = ST_CUT;
         end
         ST_CUT: begin
            cmd.step = wsts_pkg::STEP_CUT;
            state_in = ST_DSC_B;
         end
         ST_UPD_B: begin
            cmd.step = wsts_pkg::STEP_UPD_B;
            state_in = ST_UPD_C;
         end
         ST_UPD_C: begin
            cmd.step = wsts_pkg::STEP_UPD_C;
            state_in = status.at_root ? ST_DONE : ST_UPD_B;
         end
         ST_DSC_RD: begin
            cmd.step = wsts_pkg::STEP_DSC_RD;
            state_in = ST_DSC_B;
         end
         ST_DSC_B: begin
            cmd.step = wsts_pkg::STEP_DSC_B;
            state_in = ST_DSC_C;
         end
         ST_DSC_C: begin
            cmd.step = wsts_pkg::STEP_DSC_C;
            state_in = status.dsc_stop ? ST_DONE : ST_DSC_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_FETCH)
      else $error("accepted word did not start a fetch");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready && !cmd.load)
      else $error("request taken during clearing pass");

endmodule
